[rtl/core/tagged_length_frame_receiver_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the tagged length frame receiver
// Concurrent assertion wrappers clocked on aclk; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef TAGGED_LENGTH_FRAME_RECEIVER_CORE_ASSERT_SVH
`define TAGGED_LENGTH_FRAME_RECEIVER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define TLFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked on every edge, reset included
`define TLFR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define TLFR_ASSERT(label, prop, msg)
`define TLFR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[rtl/core/tlfr_pkg.sv]
// ----------------------------------------------------------------------------
// tlfr_pkg
// Types and constants shared by the tagged length frame receiver modules.
// ----------------------------------------------------------------------------
package tlfr_pkg;

    // header magic bytes
    localparam logic [7:0]  MAGIC_0           = 8'h50;
    localparam logic [7:0]  MAGIC_1           = 8'h53;
    // header byte index of the final header byte
    localparam logic [2:0]  HDR_LAST          = 3'd7;
    // cap on delivered payload bytes after reset
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd4096;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HDR_BYTE  = 3'd0,
        KIND_HDR_GOOD  = 3'd1,
        KIND_PAYLOAD   = 3'd2,
        KIND_SKIPPED   = 3'd3,
        KIND_BAD_MAGIC = 3'd4
    } kind_t;

    typedef struct packed {
        phase_t       phase;
        logic [2:0]   hdr_count;
        logic [63:0]  hdr_shift;
        logic [31:0]  remaining;
        logic [31:0]  delivered;
    } state_t;

    typedef struct packed {
        kind_t        kind;
        logic [7:0]   data_byte;
        logic [15:0]  msg_id;
        logic [31:0]  msg_len;
        logic [31:0]  delivered_count;
        logic         last;
    } result_t;

endpackage

[rtl/core/tlfr_step.sv]
// ----------------------------------------------------------------------------
// tlfr_step
// Per-byte deframing logic: next frame state and the result for one byte.
// ----------------------------------------------------------------------------
module tlfr_step
    import tlfr_pkg::*;
(
    input  state_t      state,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] max_payload,
    output state_t      state_next,
    output result_t     result
);

    logic [63:0] shifted;
    logic [31:0] hdr_len;
    logic [15:0] hdr_id;
    logic [31:0] remaining_dec;
    logic [31:0] delivered_inc;

    // header shift, restarted on the first header byte
    assign shifted = (state.hdr_count == 3'd0) ? {56'd0, rx_byte}
                                               : {state.hdr_shift[55:0], rx_byte};
    assign remaining_dec = state.remaining - 32'd1;
    assign delivered_inc = state.delivered + 32'd1;

    // id and length: stored header in payload phase, fresh header at its end
    always_comb begin
        if (state.phase == PH_PAYLOAD) begin
            hdr_id  = state.hdr_shift[47:32];
            hdr_len = state.hdr_shift[31:0];
        end else begin
            hdr_id  = shifted[47:32];
            hdr_len = shifted[31:0];
        end
    end

    // next state and result
    always_comb begin
        state_next = state;
        result     = '0;
        case (state.phase)
            PH_PAYLOAD: begin
                if (state.delivered < max_payload) begin
                    result.kind          = KIND_PAYLOAD;
                    result.data_byte     = rx_byte;
                    state_next.delivered = delivered_inc;
                end else begin
                    result.kind = KIND_SKIPPED;
                end
                state_next.remaining   = remaining_dec;
                result.msg_id          = hdr_id;
                result.msg_len         = hdr_len;
                result.delivered_count = state_next.delivered;
                result.last            = (remaining_dec == 32'd0);
                if (remaining_dec == 32'd0) begin
                    state_next.phase     = PH_HEADER;
                    state_next.hdr_count = 3'd0;
                end
            end
            default: begin
                // header collection, unused phase codes included
                state_next.phase     = PH_HEADER;
                state_next.hdr_shift = shifted;
                state_next.hdr_count = state.hdr_count + 3'd1;
                result.kind          = KIND_HDR_BYTE;
                if (state.hdr_count == HDR_LAST) begin
                    if (shifted[63:56] != MAGIC_0 || shifted[55:48] != MAGIC_1) begin
                        state_next.hdr_shift = '0;
                        result.kind          = KIND_BAD_MAGIC;
                    end else begin
                        state_next.delivered = 32'd0;
                        state_next.remaining = hdr_len;
                        result.kind          = KIND_HDR_GOOD;
                        result.msg_id        = hdr_id;
                        if (hdr_len == 32'd0) begin
                            result.last = 1'b1;
                        end else begin
                            state_next.phase = PH_PAYLOAD;
                            result.msg_len   = hdr_len;
                        end
                    end
                end
            end
        endcase
    end

endmodule

[rtl/core/tagged_length_frame_receiver_core.sv]
// ----------------------------------------------------------------------------
// tagged_length_frame_receiver_core
// Byte-stream deframer for magic/id/length tagged messages.
// ----------------------------------------------------------------------------
// One byte is taken per clock while the input is not stalled, and each gives
// exactly one result, which appears in the output register the cycle after
// the byte is accepted. A new byte is accepted in every cycle in which the
// output register is empty or its result is being taken, so the sustained
// rate is one byte per cycle while results are taken; the frame state update
// and the output register handshake set this rate. max_payload may be
// rewritten at any idle point and takes effect from the next payload byte.
// ----------------------------------------------------------------------------
module tagged_length_frame_receiver_core
    import tlfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    // byte requests in
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    // result requests out
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_data_byte,
    output logic [15:0] m_msg_id,
    output logic [31:0] m_msg_len,
    output logic [31:0] m_delivered_count,
    output logic        m_last
);

`include "tagged_length_frame_receiver_core_assert.svh"

    logic        accept;
    logic [31:0] max_payload_reg;
    state_t      state_reg;
    state_t      state_next;
    result_t     result_reg;
    result_t     result_next;
    logic        m_valid_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // per-byte logic
    tlfr_step u_step (
        .state       (state_reg),
        .rx_byte     (s_rx_byte),
        .max_payload (max_payload_reg),
        .state_next  (state_next),
        .result      (result_next)
    );

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end else if (cfg_we) begin
            max_payload_reg <= cfg_wdata;
        end
    end

    // frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_HEADER, hdr_count: 3'd0, hdr_shift: 64'd0,
                           remaining: 32'd0, delivered: 32'd0};
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_kind            = result_reg.kind;
    assign m_data_byte       = result_reg.data_byte;
    assign m_msg_id          = result_reg.msg_id;
    assign m_msg_len         = result_reg.msg_len;
    assign m_delivered_count = result_reg.delivered_count;
    assign m_last            = result_reg.last;

    // checks
    `TLFR_ASSERT(a_stall_means_full, !s_ready |-> m_valid_reg, "input stalled with output empty")
    `TLFR_ASSERT(a_good_hdr_enters_payload, accept && result_next.kind == KIND_HDR_GOOD && result_next.msg_len != 32'd0 |=> state_reg.phase == PH_PAYLOAD, "good header did not enter payload")
    `TLFR_ASSERT(a_last_restarts_hunt, accept && result_next.last |=> state_reg.phase == PH_HEADER && state_reg.hdr_count == 3'd0, "message end did not restart header hunt")
    `TLFR_ASSERT(a_delivered_nonzero, m_valid_reg && result_reg.kind == KIND_PAYLOAD |-> result_reg.delivered_count != 32'd0, "delivered byte with zero count")

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the tagged length frame receiver core against a cycle-free
// prediction of its framing behaviour. Byte requests are driven through the
// input handshake with random gaps, results are taken with random stalls, and
// every result is compared field by field with the predicted one. The payload
// cap is rewritten between phases while the core is idle, sometimes in the
// middle of a frame.
// ----------------------------------------------------------------------------
module testbench
    import tlfr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PRINT_LIMIT = 20;

    // framing predictor with its own copy of state and payload cap
    class frame_scoreboard;
        result_t     pending_q[$];
        phase_t      phase;
        logic [2:0]  hdr_count;
        logic [63:0] hdr_shift;
        logic [31:0] remaining;
        logic [31:0] delivered;
        logic [31:0] cap;
        int unsigned errors;
        int unsigned checked;
        int unsigned n_good;
        int unsigned n_empty;
        int unsigned n_bad;
        int unsigned n_deliv;
        int unsigned n_skip;

        function new();
            phase     = PH_HEADER;
            hdr_count = '0;
            hdr_shift = '0;
            remaining = '0;
            delivered = '0;
            cap       = MAX_PAYLOAD_RESET;
            errors    = 0;
            checked   = 0;
            n_good    = 0;
            n_empty   = 0;
            n_bad     = 0;
            n_deliv   = 0;
            n_skip    = 0;
        endfunction

        function void set_cap(logic [31:0] value);
            cap = value;
        endfunction

        function int unsigned pending();
            return pending_q.size();
        endfunction

        // work out the result of one accepted byte request
        function void note_request(logic [7:0] b);
            result_t r;
            r = '0;
            if (phase == PH_PAYLOAD) begin
                r.msg_id  = hdr_shift[47:32];
                r.msg_len = hdr_shift[31:0];
                if (delivered < cap) begin
                    r.kind      = KIND_PAYLOAD;
                    r.data_byte = b;
                    delivered   = delivered + 32'd1;
                    n_deliv++;
                end else begin
                    r.kind = KIND_SKIPPED;
                    n_skip++;
                end
                remaining         = remaining - 32'd1;
                r.delivered_count = delivered;
                r.last            = (remaining == 32'd0);
                if (r.last) begin
                    phase     = PH_HEADER;
                    hdr_count = '0;
                end
            end else begin
                // header hunt, unused phase codes included
                phase = PH_HEADER;
                if (hdr_count == 3'd0)
                    hdr_shift = '0;
                hdr_shift = {hdr_shift[55:0], b};
                hdr_count = hdr_count + 3'd1;
                if (hdr_count != 3'd0) begin
                    r.kind = KIND_HDR_BYTE;
                end else if (hdr_shift[63:56] != MAGIC_0 || hdr_shift[55:48] != MAGIC_1) begin
                    hdr_shift = '0;
                    r.kind    = KIND_BAD_MAGIC;
                    n_bad++;
                end else begin
                    delivered = '0;
                    remaining = hdr_shift[31:0];
                    r.kind    = KIND_HDR_GOOD;
                    r.msg_id  = hdr_shift[47:32];
                    if (remaining == 32'd0) begin
                        r.last = 1'b1;
                        n_empty++;
                    end else begin
                        phase     = PH_PAYLOAD;
                        r.msg_len = remaining;
                    end
                    n_good++;
                end
            end
            pending_q.push_back(r);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t mismatch on %s: got 0x%0h, wanted 0x%0h", $realtime, what, got,
                         want);
        endtask

        // compare one accepted result with the oldest prediction
        task check_result(result_t got);
            result_t want;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result kind", 64'(got.kind), '0);
            end else begin
                want = pending_q.pop_front();
                checked++;
                if (got.kind != want.kind)
                    report_mismatch("kind", 64'(got.kind), 64'(want.kind));
                if (got.data_byte != want.data_byte)
                    report_mismatch("data_byte", 64'(got.data_byte), 64'(want.data_byte));
                if (got.msg_id != want.msg_id)
                    report_mismatch("msg_id", 64'(got.msg_id), 64'(want.msg_id));
                if (got.msg_len != want.msg_len)
                    report_mismatch("msg_len", 64'(got.msg_len), 64'(want.msg_len));
                if (got.delivered_count != want.delivered_count)
                    report_mismatch("delivered_count", 64'(got.delivered_count),
                                    64'(want.delivered_count));
                if (got.last != want.last)
                    report_mismatch("last", 64'(got.last), 64'(want.last));
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_kind;
    logic [7:0]  m_data_byte;
    logic [15:0] m_msg_id;
    logic [31:0] m_msg_len;
    logic [31:0] m_delivered_count;
    logic        m_last;

    frame_scoreboard sb = new();
    logic [7:0]      stream_q[$];
    int unsigned     idle_pct = 0;
    int unsigned     stall_pct = 0;
    int unsigned     sent = 0;
    int unsigned     cap_writes = 0;

    tagged_length_frame_receiver_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_data_byte       (m_data_byte),
        .m_msg_id          (m_msg_id),
        .m_msg_len         (m_msg_len),
        .m_delivered_count (m_delivered_count),
        .m_last            (m_last)
    );

    always #5 aclk = ~aclk;

    // result side: take results and stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{kind: kind_t'(m_kind), data_byte: m_data_byte, msg_id: m_msg_id,
                              msg_len: m_msg_len, delivered_count: m_delivered_count,
                              last: m_last});
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog on cycles with no request moving on either side
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    function void push_header(logic [7:0] m0, logic [7:0] m1, logic [15:0] id,
                              logic [31:0] len);
        stream_q.push_back(m0);
        stream_q.push_back(m1);
        stream_q.push_back(id[15:8]);
        stream_q.push_back(id[7:0]);
        stream_q.push_back(len[31:24]);
        stream_q.push_back(len[23:16]);
        stream_q.push_back(len[15:8]);
        stream_q.push_back(len[7:0]);
    endfunction

    // mostly good frames, some junk and some corrupted magic
    function void queue_frame();
        int unsigned pick;
        int unsigned len;
        logic [7:0]  m0;
        logic [7:0]  m1;
        logic [7:0]  flip;
        pick = $urandom_range(99);
        if (pick < 10) begin
            repeat (8) stream_q.push_back(8'($urandom));
        end else if (pick < 20) begin
            m0   = MAGIC_0;
            m1   = MAGIC_1;
            flip = 8'($urandom_range(255, 1));
            case ($urandom_range(2))
                0: m0 = m0 ^ flip;
                1: m1 = m1 ^ flip;
                default: begin
                    m0 = m0 ^ flip;
                    m1 = m1 ^ flip;
                end
            endcase
            push_header(m0, m1, 16'($urandom), $urandom_range(12));
        end else begin
            if (pick < 30)
                len = 0;
            else if ($urandom_range(9) == 0)
                len = $urandom_range(64);
            else
                len = $urandom_range(12, 1);
            push_header(MAGIC_0, MAGIC_1, 16'($urandom), len);
            repeat (len) stream_q.push_back(8'($urandom));
        end
    endfunction

    // one byte request, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(b);
        sent++;
    endtask

    // hold the sender until every result is back
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cap(input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_cap(value);
        cap_writes++;
    endtask

    task automatic run_phase(input logic [31:0] cap, input int unsigned idle,
                             input int unsigned stall, input int unsigned count);
        drain();
        write_cap(cap);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count) begin
            if (stream_q.size() == 0)
                queue_frame();
            send_byte(stream_q.pop_front());
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: byte extremes, empty message, bad magic, reset cap
        push_header(MAGIC_0, MAGIC_1, 16'hFFFF, 32'd2);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'hFF);
        push_header(MAGIC_0, MAGIC_1, 16'h0000, 32'd0);
        push_header(MAGIC_0, 8'h54, 16'h1234, 32'd5);
        while (stream_q.size() != 0)
            send_byte(stream_q.pop_front());

        // random phases over caps and idling patterns
        run_phase(32'd0, 0, 0, 170);
        run_phase(32'd3, 57, 0, 180);
        run_phase($urandom_range(16, 1), 0, 57, 180);
        run_phase(32'hFFFF_FFFF, 33, 33, 180);
        run_phase($urandom, 0, 0, 180);
        run_phase(32'd1, 33, 33, 180);

        // longest announced length, left open at the end of the run
        push_header(MAGIC_0, MAGIC_1, 16'($urandom), 32'hFFFF_FFFF);
        repeat (6) stream_q.push_back(8'($urandom));
        run_phase(32'd2, 33, 33, stream_q.size());
        drain();

        $display("sent %0d bytes, checked %0d results, %0d cap writes", sent, sb.checked,
                 cap_writes);
        $display("frames: %0d good (%0d empty), %0d bad magic; payload %0d delivered, %0d skipped",
                 sb.n_good, sb.n_empty, sb.n_bad, sb.n_deliv, sb.n_skip);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
